>>> rtl/sia_pkg.sv
// shared types and constants for the segment intersection unit
// no dependencies
`default_nettype none

package sia_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FIFO_DEPTH     = 4;

	typedef enum logic [1:0] {
		REL_NONE    = 2'd0,
		REL_CROSS   = 2'd1,
		REL_OVERLAP = 2'd2
	} rel_t;

endpackage

`default_nettype wire

>>> rtl/sia_fifo.sv
// small register queue with push/full and pop/empty sides
// depends on sia_pkg for the default depth
`default_nettype none

module sia_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = sia_pkg::FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/sia_front.sv
// front pipeline: cross products, classification and numerator products
// depends on sia_pkg for the relation codes
`default_nettype none

module sia_front #(
	parameter int COORD_BITS = sia_pkg::COORD_BITS_DEF,
	localparam int C  = COORD_BITS,
	localparam int DW = C + 1,
	localparam int PW = 2 * DW,
	localparam int XW = PW + 1,
	localparam int MW = DW + XW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic signed [C-1:0]  p_start_x,
	input  logic signed [C-1:0]  p_start_y,
	input  logic signed [C-1:0]  p_end_x,
	input  logic signed [C-1:0]  p_end_y,
	input  logic signed [C-1:0]  q_start_x,
	input  logic signed [C-1:0]  q_start_y,
	input  logic signed [C-1:0]  q_end_x,
	input  logic signed [C-1:0]  q_end_y,
	output logic                 job_valid,
	input  logic                 job_full,
	output logic [1:0]           job_rel,
	output logic signed [XW-1:0] job_d,
	output logic signed [MW-1:0] job_n0,
	output logic signed [MW-1:0] job_n1,
	output logic signed [MW-1:0] job_n2,
	output logic signed [MW-1:0] job_n3,
	output logic signed [C-1:0]  job_b0,
	output logic signed [C-1:0]  job_b1,
	output logic signed [C-1:0]  job_b2,
	output logic signed [C-1:0]  job_b3
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// stage 1: differences
	logic signed [DW-1:0] dpx_s1, dpy_s1, dqx_s1, dqy_s1, wx_s1, wy_s1, bx_s1, by_s1;
	logic signed [C-1:0]  p1x_s1, p1y_s1, q1x_s1, q1y_s1;
	// stage 2: products and collinear axis choice
	logic signed [PW-1:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;
	logic signed [DW-1:0] dpx_s2, dpy_s2, dqx_s2, dqy_s2, a0_s2, b0_s2, d0_s2;
	logic                 qz_s2;
	logic signed [C-1:0]  p1x_s2, p1y_s2, q1x_s2, q1y_s2;
	// stage 3: cross products, ordered positions along q
	logic signed [XW-1:0] den_s3, sn_s3, tn_s3;
	logic signed [DW-1:0] lo_s3, hi_s3, dd_s3, dpx_s3, dpy_s3, dqx_s3, dqy_s3;
	logic                 qz_s3;
	logic signed [C-1:0]  p1x_s3, p1y_s3, q1x_s3, q1y_s3;
	// stage 4: sign normalized, clamped
	logic signed [XW-1:0] dn_s4, snn_s4, tnn_s4;
	logic                 denz_s4, coll_s4, cok_s4;
	logic signed [DW-1:0] lo_s4, hi_s4, dd_s4, dpx_s4, dpy_s4, dqx_s4, dqy_s4;
	logic signed [C-1:0]  p1x_s4, p1y_s4, q1x_s4, q1y_s4;
	// stage 5: relation and multiplier operands
	sia_pkg::rel_t        rel_s5;
	logic signed [XW-1:0] d_s5, bl_s5, bh_s5;
	logic signed [DW-1:0] a0_s5, a1_s5, a2_s5, a3_s5;
	logic signed [C-1:0]  b0_s5, b1_s5, b2_s5, b3_s5;
	// stage 6: numerators
	sia_pkg::rel_t        rel_s6;
	logic signed [XW-1:0] d_s6;
	logic signed [MW-1:0] n0_s6, n1_s6, n2_s6, n3_s6;
	logic signed [C-1:0]  b0_s6, b1_s6, b2_s6, b3_s6;

	logic signed [DW-1:0] adqx, adqy;
	logic                 selx;
	logic signed [DW-1:0] na, nb, nd;
	logic                 dneg;
	logic                 cross_ok;
	sia_pkg::rel_t        rel_c;

	assign en        = !(v_s6 && job_full);
	assign full      = !en;
	assign job_valid = v_s6 && !job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dpx_s1 <= DW'(p_end_x) - DW'(p_start_x);
			dpy_s1 <= DW'(p_end_y) - DW'(p_start_y);
			dqx_s1 <= DW'(q_end_x) - DW'(q_start_x);
			dqy_s1 <= DW'(q_end_y) - DW'(q_start_y);
			wx_s1  <= DW'(p_start_x) - DW'(q_start_x);
			wy_s1  <= DW'(p_start_y) - DW'(q_start_y);
			bx_s1  <= DW'(p_end_x) - DW'(q_start_x);
			by_s1  <= DW'(p_end_y) - DW'(q_start_y);
			p1x_s1 <= p_start_x;
			p1y_s1 <= p_start_y;
			q1x_s1 <= q_start_x;
			q1y_s1 <= q_start_y;
		end
	end

	always_comb begin
		adqx = dqx_s1[DW-1] ? -dqx_s1 : dqx_s1;
		adqy = dqy_s1[DW-1] ? -dqy_s1 : dqy_s1;
		selx = adqx > adqy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m0_s2  <= PW'(dpx_s1) * PW'(dqy_s1);
			m1_s2  <= PW'(dpy_s1) * PW'(dqx_s1);
			m2_s2  <= PW'(dqx_s1) * PW'(wy_s1);
			m3_s2  <= PW'(dqy_s1) * PW'(wx_s1);
			m4_s2  <= PW'(dpx_s1) * PW'(wy_s1);
			m5_s2  <= PW'(dpy_s1) * PW'(wx_s1);
			a0_s2  <= selx ? wx_s1 : wy_s1;
			b0_s2  <= selx ? bx_s1 : by_s1;
			d0_s2  <= selx ? dqx_s1 : dqy_s1;
			qz_s2  <= (dqx_s1 == '0) && (dqy_s1 == '0);
			dpx_s2 <= dpx_s1;
			dpy_s2 <= dpy_s1;
			dqx_s2 <= dqx_s1;
			dqy_s2 <= dqy_s1;
			p1x_s2 <= p1x_s1;
			p1y_s2 <= p1y_s1;
			q1x_s2 <= q1x_s1;
			q1y_s2 <= q1y_s1;
		end
	end

	// positions along q in units of dq, made to run forward
	always_comb begin
		na = d0_s2[DW-1] ? -a0_s2 : a0_s2;
		nb = d0_s2[DW-1] ? -b0_s2 : b0_s2;
		nd = d0_s2[DW-1] ? -d0_s2 : d0_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3 <= XW'(m0_s2) - XW'(m1_s2);
			sn_s3  <= XW'(m2_s2) - XW'(m3_s2);
			tn_s3  <= XW'(m4_s2) - XW'(m5_s2);
			lo_s3  <= (na > nb) ? nb : na;
			hi_s3  <= (na > nb) ? na : nb;
			dd_s3  <= nd;
			qz_s3  <= qz_s2;
			dpx_s3 <= dpx_s2;
			dpy_s3 <= dpy_s2;
			dqx_s3 <= dqx_s2;
			dqy_s3 <= dqy_s2;
			p1x_s3 <= p1x_s2;
			p1y_s3 <= p1y_s2;
			q1x_s3 <= q1x_s2;
			q1y_s3 <= q1y_s2;
		end
	end

	assign dneg = den_s3[XW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			dn_s4   <= dneg ? -den_s3 : den_s3;
			snn_s4  <= dneg ? -sn_s3 : sn_s3;
			tnn_s4  <= dneg ? -tn_s3 : tn_s3;
			denz_s4 <= (den_s3 == '0);
			coll_s4 <= (den_s3 == '0) && (sn_s3 == '0) && (tn_s3 == '0) && !qz_s3;
			cok_s4  <= !((lo_s3 > dd_s3) || hi_s3[DW-1]);
			lo_s4   <= lo_s3[DW-1] ? '0 : lo_s3;
			hi_s4   <= (hi_s3 > dd_s3) ? dd_s3 : hi_s3;
			dd_s4   <= dd_s3;
			dpx_s4  <= dpx_s3;
			dpy_s4  <= dpy_s3;
			dqx_s4  <= dqx_s3;
			dqy_s4  <= dqy_s3;
			p1x_s4  <= p1x_s3;
			p1y_s4  <= p1y_s3;
			q1x_s4  <= q1x_s3;
			q1y_s4  <= q1y_s3;
		end
	end

	always_comb begin
		cross_ok = !denz_s4 && !snn_s4[XW-1] && (snn_s4 <= dn_s4) &&
			!tnn_s4[XW-1] && (tnn_s4 <= dn_s4);
		if (cross_ok) begin
			rel_c = sia_pkg::REL_CROSS;
		end else if (coll_s4 && cok_s4) begin
			rel_c = (lo_s4 == hi_s4) ? sia_pkg::REL_CROSS : sia_pkg::REL_OVERLAP;
		end else begin
			rel_c = sia_pkg::REL_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rel_s5 <= rel_c;
			if (!denz_s4) begin
				d_s5  <= dn_s4;
				a0_s5 <= dpx_s4;
				a1_s5 <= dpy_s4;
				bl_s5 <= snn_s4;
				b0_s5 <= p1x_s4;
				b1_s5 <= p1y_s4;
			end else begin
				d_s5  <= XW'(dd_s4);
				a0_s5 <= dqx_s4;
				a1_s5 <= dqy_s4;
				bl_s5 <= XW'(lo_s4);
				b0_s5 <= q1x_s4;
				b1_s5 <= q1y_s4;
			end
			a2_s5 <= dqx_s4;
			a3_s5 <= dqy_s4;
			bh_s5 <= XW'(hi_s4);
			b2_s5 <= q1x_s4;
			b3_s5 <= q1y_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rel_s6 <= rel_s5;
			d_s6   <= d_s5;
			n0_s6  <= MW'(a0_s5) * MW'(bl_s5);
			n1_s6  <= MW'(a1_s5) * MW'(bl_s5);
			n2_s6  <= MW'(a2_s5) * MW'(bh_s5);
			n3_s6  <= MW'(a3_s5) * MW'(bh_s5);
			b0_s6  <= b0_s5;
			b1_s6  <= b1_s5;
			b2_s6  <= b2_s5;
			b3_s6  <= b3_s5;
		end
	end

	assign job_rel = rel_s6;
	assign job_d   = d_s6;
	assign job_n0  = n0_s6;
	assign job_n1  = n1_s6;
	assign job_n2  = n2_s6;
	assign job_n3  = n3_s6;
	assign job_b0  = b0_s6;
	assign job_b1  = b1_s6;
	assign job_b2  = b2_s6;
	assign job_b3  = b3_s6;

endmodule

`default_nettype wire

>>> rtl/sia_back.sv
// back pipeline: four rounding dividers, one quotient bit per stage, then offset and saturate
// depends on sia_pkg for the relation codes
`default_nettype none

module sia_back #(
	parameter int COORD_BITS = sia_pkg::COORD_BITS_DEF,
	localparam int C  = COORD_BITS,
	localparam int DW = C + 1,
	localparam int PW = 2 * DW,
	localparam int XW = PW + 1,
	localparam int MW = DW + XW,
	localparam int QW = C + 2,
	localparam int NW = QW + XW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_pop,
	input  logic [1:0]           job_rel,
	input  logic signed [XW-1:0] job_d,
	input  logic signed [MW-1:0] job_n0,
	input  logic signed [MW-1:0] job_n1,
	input  logic signed [MW-1:0] job_n2,
	input  logic signed [MW-1:0] job_n3,
	input  logic signed [C-1:0]  job_b0,
	input  logic signed [C-1:0]  job_b1,
	input  logic signed [C-1:0]  job_b2,
	input  logic signed [C-1:0]  job_b3,
	output logic                 res_push,
	input  logic                 res_full,
	output logic [1:0]           res_rel,
	output logic signed [C-1:0]  res_c0,
	output logic signed [C-1:0]  res_c1,
	output logic signed [C-1:0]  res_c2,
	output logic signed [C-1:0]  res_c3
);

	localparam logic signed [QW+1:0] SAT_HI = {{(QW + 3 - C){1'b0}}, {(C - 1){1'b1}}};
	localparam logic signed [QW+1:0] SAT_LO = ~SAT_HI;
	localparam logic [QW:0]          Q_OFF  = (QW + 1)'(1) << (C + 1);

	logic              en;
	logic [QW+1:0]     vld_s;
	logic [NW-1:0]     rem_s  [0:QW][4];
	logic [QW-1:0]     quo_s  [0:QW][4];
	logic [XW:0]       d2_s   [0:QW];
	logic signed [C-1:0] base_s [0:QW][4];
	logic [1:0]        rel_s  [0:QW];
	logic [1:0]        fin_rel_s;
	logic signed [C-1:0] fin_c_s [4];

	logic signed [MW-1:0] n_in [4];
	logic signed [C-1:0]  b_in [4];
	logic [NW:0]          nprep [4];
	logic signed [QW+1:0] sum [4];
	logic signed [QW:0]   qv [4];
	logic [3:0]           keep;
	logic signed [C-1:0]  sat [4];

	assign en       = !(vld_s[QW+1] && res_full);
	assign job_pop  = en && job_valid;
	assign res_push = vld_s[QW+1] && !res_full;

	assign n_in[0] = job_n0;
	assign n_in[1] = job_n1;
	assign n_in[2] = job_n2;
	assign n_in[3] = job_n3;
	assign b_in[0] = job_b0;
	assign b_in[1] = job_b1;
	assign b_in[2] = job_b2;
	assign b_in[3] = job_b3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QW:0], job_valid};
		end
	end

	// floor((2n + d) / 2d) computed as floor((2n + d + 2d * 2^(C+1)) / 2d) - 2^(C+1)
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			nprep[l] = ({{(NW + 1 - MW){n_in[l][MW-1]}}, n_in[l]} << 1) +
				{{(NW + 1 - XW){1'b0}}, job_d} +
				({{(NW + 1 - XW){1'b0}}, job_d} << QW);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s[0]  <= {job_d, 1'b0};
			rel_s[0] <= job_rel;
			for (int l = 0; l < 4; l++) begin
				rem_s[0][l]  <= nprep[l][NW-1:0];
				quo_s[0][l]  <= '0;
				base_s[0][l] <= b_in[l];
			end
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_div
		localparam int SH = QW - k;
		logic [NW:0] dsh;
		logic [NW:0] sub [4];

		always_comb begin
			dsh = {{(NW - XW){1'b0}}, d2_s[k-1]} << SH;
			for (int l = 0; l < 4; l++) begin
				sub[l] = {1'b0, rem_s[k-1][l]} - dsh;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d2_s[k]  <= d2_s[k-1];
				rel_s[k] <= rel_s[k-1];
				for (int l = 0; l < 4; l++) begin
					base_s[k][l] <= base_s[k-1][l];
					if (!sub[l][NW]) begin
						rem_s[k][l] <= sub[l][NW-1:0];
						quo_s[k][l] <= quo_s[k-1][l] | (QW'(1) << SH);
					end else begin
						rem_s[k][l] <= rem_s[k-1][l];
						quo_s[k][l] <= quo_s[k-1][l];
					end
				end
			end
		end
	end

	// unused coordinates read as zero
	always_comb begin
		keep[0] = (rel_s[QW] != sia_pkg::REL_NONE);
		keep[1] = keep[0];
		keep[2] = (rel_s[QW] == sia_pkg::REL_OVERLAP);
		keep[3] = keep[2];
		for (int l = 0; l < 4; l++) begin
			qv[l]  = $signed({1'b0, quo_s[QW][l]} - Q_OFF);
			sum[l] = (QW + 2)'(base_s[QW][l]) + (QW + 2)'(qv[l]);
			if (sum[l] > SAT_HI) begin
				sat[l] = SAT_HI[C-1:0];
			end else if (sum[l] < SAT_LO) begin
				sat[l] = SAT_LO[C-1:0];
			end else begin
				sat[l] = sum[l][C-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_rel_s <= rel_s[QW];
			for (int l = 0; l < 4; l++) begin
				fin_c_s[l] <= keep[l] ? sat[l] : '0;
			end
		end
	end

	assign res_rel = fin_rel_s;
	assign res_c0  = fin_c_s[0];
	assign res_c1  = fin_c_s[1];
	assign res_c2  = fin_c_s[2];
	assign res_c3  = fin_c_s[3];

endmodule

`default_nettype wire

>>> rtl/segment_intersect_2d_unit.sv
// top level of the 2d segment intersection unit
// depends on sia_pkg, sia_fifo, sia_front and sia_back
//
// usage
//   input side is a queue: drive the eight endpoint coordinates with push;
//   a pair is taken at a rising edge with push high and full low.
//   result side is a queue: while empty is low the oldest result sits on
//   relation, first_x/y, second_x/y; pop high with empty low takes it.
//   relation: none, cross at a point, or collinear overlap; unused
//   coordinates are zero.
// throughput: one pair per cycle while full stays low, set by the front
//   pipeline and the bit-per-stage dividers, both fully pipelined.
// path from transfer to result: six front stages, the job queue,
//   COORD_BITS + 4 back stages with one quotient bit per divider stage,
//   and the result queue.
// reset: arst_n low empties both queues and all pipeline valids; no clearing
//   pass, full is low right after reset.
// stall: while pop is held off the back pipeline freezes once the result
//   queue fills, then the job queue fills, then the front freezes and full
//   rises; no result is dropped or repeated.
`default_nettype none

module segment_intersect_2d_unit #(
	parameter int COORD_BITS = sia_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_BITS-1:0]  p_start_x,
	input  logic signed [COORD_BITS-1:0]  p_start_y,
	input  logic signed [COORD_BITS-1:0]  p_end_x,
	input  logic signed [COORD_BITS-1:0]  p_end_y,
	input  logic signed [COORD_BITS-1:0]  q_start_x,
	input  logic signed [COORD_BITS-1:0]  q_start_y,
	input  logic signed [COORD_BITS-1:0]  q_end_x,
	input  logic signed [COORD_BITS-1:0]  q_end_y,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    relation,
	output logic signed [COORD_BITS-1:0]  first_x,
	output logic signed [COORD_BITS-1:0]  first_y,
	output logic signed [COORD_BITS-1:0]  second_x,
	output logic signed [COORD_BITS-1:0]  second_y
);

	localparam int C  = COORD_BITS;
	localparam int DW = C + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;
	localparam int MW = DW + XW;
	localparam int JW = 2 + XW + 4 * MW + 4 * C;
	localparam int OW = 2 + 4 * C;

	logic                 fj_valid;
	logic                 mid_full;
	logic                 mid_empty;
	logic                 mid_pop;
	logic [1:0]           fj_rel, bj_rel;
	logic signed [XW-1:0] fj_d, bj_d;
	logic signed [MW-1:0] fj_n0, fj_n1, fj_n2, fj_n3;
	logic signed [MW-1:0] bj_n0, bj_n1, bj_n2, bj_n3;
	logic signed [C-1:0]  fj_b0, fj_b1, fj_b2, fj_b3;
	logic signed [C-1:0]  bj_b0, bj_b1, bj_b2, bj_b3;
	logic [JW-1:0]        mid_wdata, mid_rdata;

	logic                 res_push;
	logic                 res_full;
	logic [1:0]           res_rel;
	logic signed [C-1:0]  res_c0, res_c1, res_c2, res_c3;
	logic [OW-1:0]        out_wdata, out_rdata;

	sia_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.p_start_x (p_start_x),
		.p_start_y (p_start_y),
		.p_end_x   (p_end_x),
		.p_end_y   (p_end_y),
		.q_start_x (q_start_x),
		.q_start_y (q_start_y),
		.q_end_x   (q_end_x),
		.q_end_y   (q_end_y),
		.job_valid (fj_valid),
		.job_full  (mid_full),
		.job_rel   (fj_rel),
		.job_d     (fj_d),
		.job_n0    (fj_n0),
		.job_n1    (fj_n1),
		.job_n2    (fj_n2),
		.job_n3    (fj_n3),
		.job_b0    (fj_b0),
		.job_b1    (fj_b1),
		.job_b2    (fj_b2),
		.job_b3    (fj_b3)
	);

	assign mid_wdata = {fj_rel, fj_d, fj_n0, fj_n1, fj_n2, fj_n3,
		fj_b0, fj_b1, fj_b2, fj_b3};

	sia_fifo #(.W(JW)) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fj_valid),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign {bj_rel, bj_d, bj_n0, bj_n1, bj_n2, bj_n3,
		bj_b0, bj_b1, bj_b2, bj_b3} = mid_rdata;

	sia_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!mid_empty),
		.job_pop   (mid_pop),
		.job_rel   (bj_rel),
		.job_d     (bj_d),
		.job_n0    (bj_n0),
		.job_n1    (bj_n1),
		.job_n2    (bj_n2),
		.job_n3    (bj_n3),
		.job_b0    (bj_b0),
		.job_b1    (bj_b1),
		.job_b2    (bj_b2),
		.job_b3    (bj_b3),
		.res_push  (res_push),
		.res_full  (res_full),
		.res_rel   (res_rel),
		.res_c0    (res_c0),
		.res_c1    (res_c1),
		.res_c2    (res_c2),
		.res_c3    (res_c3)
	);

	assign out_wdata = {res_rel, res_c0, res_c1, res_c2, res_c3};

	sia_fifo #(.W(OW)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (out_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign {relation, first_x, first_y, second_x, second_y} = out_rdata;

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && relation == sia_pkg::REL_NONE) |->
		(first_x == '0 && first_y == '0 && second_x == '0 && second_y == '0))
		else $error("disjoint result with nonzero coordinates");

	a_cross_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && relation == sia_pkg::REL_CROSS) |-> (second_x == '0 && second_y == '0))
		else $error("crossing result with nonzero second point");

	a_full_backs: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> mid_full)
		else $error("input stalled while job queue has room");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("job queue popped while empty");

endmodule

`default_nettype wire
